// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define ZZRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next cycle
`define ZZRC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define ZZRC_ASSERT(label, clk, rst, prop, msg)
`define ZZRC_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

// ===== sv/zzrc_pkg.sv =====
// types, constants and helper functions of the zero run coder
package zzrc_pkg;

   localparam int BlockSide = 8;
   localparam int BlockLen = BlockSide * BlockSide;
   localparam int PosWidth = $clog2(BlockLen);

   localparam int CoeffWidth = 16;
   localparam int RunWidth = 6;
   localparam int WidthWidth = 5;
   localparam int CountWidth = 7;

   localparam int QueueDepth = 4;
   localparam int QueueIdxWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   typedef enum logic {
      KIND_ENTRY = 1'b0,
      KIND_HEADER = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [RunWidth-1:0] zero_run;
      logic [WidthWidth-1:0] width;
      logic signed [CoeffWidth-1:0] value;
      logic [CountWidth-1:0] element_count;
      logic end_of_block;
   } rsp_type;

   typedef struct packed {
      logic entry_valid;
      logic header_valid;
      rsp_type entry;
      rsp_type header;
   } scan_out_type;

   // minimal two's complement width of a nonzero coefficient
   function automatic logic [WidthWidth-1:0] signed_width(
      input logic signed [CoeffWidth-1:0] c);
      logic [CoeffWidth-1:0] mag;
      logic [WidthWidth-1:0] n;
      mag = c[CoeffWidth-1] ? ~c : c;
      n = '0;
      for (int i = 0; i < CoeffWidth - 1; i++) begin
         if (mag[i]) begin
            n = WidthWidth'(i + 1);
         end
      end
      return n + WidthWidth'(1);
   endfunction

   // bit length of the covered count
   function automatic logic [WidthWidth-1:0] count_bits(input logic [CountWidth-1:0] v);
      logic [WidthWidth-1:0] n;
      n = '0;
      for (int i = 0; i < CountWidth; i++) begin
         if (v[i]) begin
            n = WidthWidth'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

// ===== sv/zzrc_req_if.sv =====
// coefficient input channel
interface zzrc_req_if import zzrc_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [CoeffWidth-1:0] coeff;

   modport source (output valid, output coeff, input ready);
   modport sink (input valid, input coeff, output ready);
endinterface

// ===== sv/zzrc_rsp_if.sv =====
// result output channel
interface zzrc_rsp_if import zzrc_pkg::*; ();
   logic valid;
   logic ready;
   logic kind;
   logic [RunWidth-1:0] zero_run;
   logic [WidthWidth-1:0] width;
   logic signed [CoeffWidth-1:0] value;
   logic [CountWidth-1:0] element_count;
   logic end_of_block;

   modport source (output valid, output kind, output zero_run, output width,
                   output value, output element_count, output end_of_block,
                   input ready);
   modport sink (input valid, input kind, input zero_run, input width,
                 input value, input element_count, input end_of_block,
                 output ready);
endinterface

// ===== sv/zigzag_zero_run_coder.sv =====
// an item is registered on accept, and its results are written into the result queue once the queue has room
// the first result is offered from the queue after that write
// throughput: one item per cycle while the queue has room; a block's last coefficient that is nonzero gives two
// results, which both leave through the four-entry result queue
// the input stalls while an item is held and three or more results wait in the queue
// reset: synchronous, clears block position, run, widest entry, covered count and queue
module zigzag_zero_run_coder import zzrc_pkg::*; (
   input  logic clock,
   input  logic reset,
   zzrc_req_if.sink req_bus,
   zzrc_rsp_if.source rsp_bus
);

   logic signed [CoeffWidth-1:0] coeff_ff;
   logic hold_ff, hold_in;
   logic fire;
   logic room;
   logic accept;
   scan_out_type scan_out;
   rsp_type head;

   zzrc_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .coeff    (coeff_ff),
      .scan_out (scan_out)
   );

   zzrc_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (fire),
      .scan_out  (scan_out),
      .room      (room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (head)
   );

   always_comb begin
      fire = hold_ff && room;
      req_bus.ready = !hold_ff || fire;
      accept = req_bus.valid && req_bus.ready;
      hold_in = accept ? 1'b1 : (fire ? 1'b0 : hold_ff);

      rsp_bus.kind = head.kind;
      rsp_bus.zero_run = head.zero_run;
      rsp_bus.width = head.width;
      rsp_bus.value = head.value;
      rsp_bus.element_count = head.element_count;
      rsp_bus.end_of_block = head.end_of_block;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         coeff_ff <= req_bus.coeff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
   end

endmodule

// ===== sv/zzrc_scan.sv =====
// block state and per-coefficient entry and header generation
`include "assert_macros.svh"
module zzrc_scan import zzrc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic fire,
   input  logic signed [CoeffWidth-1:0] coeff,
   output scan_out_type scan_out
);

   logic [PosWidth-1:0] position_ff, position_in;
   logic [RunWidth-1:0] run_ff, run_in;
   logic [WidthWidth-1:0] max_ff, max_in;
   logic [CountWidth-1:0] covered_ff, covered_in;

   logic is_nz;
   logic is_last;
   logic [WidthWidth-1:0] ent_width;
   logic [WidthWidth-1:0] max_nxt;
   logic [CountWidth-1:0] covered_nxt;
   logic [RunWidth-1:0] run_nxt;
   logic [WidthWidth-1:0] cov_width;

   always_comb begin
      is_nz = (coeff != '0);
      is_last = (position_ff == PosWidth'(BlockLen - 1));
      ent_width = signed_width(coeff);
      max_nxt = (is_nz && (ent_width > max_ff)) ? ent_width : max_ff;
      covered_nxt = is_nz ? (covered_ff + CountWidth'(run_ff) + CountWidth'(1)) : covered_ff;
      run_nxt = is_nz ? '0 : (run_ff + RunWidth'(1));
      cov_width = count_bits(covered_nxt);

      scan_out.entry_valid = is_nz;
      scan_out.entry.kind = KIND_ENTRY;
      scan_out.entry.zero_run = run_ff;
      scan_out.entry.width = ent_width;
      scan_out.entry.value = coeff;
      scan_out.entry.element_count = '0;
      scan_out.entry.end_of_block = 1'b0;

      scan_out.header_valid = is_last;
      scan_out.header.kind = KIND_HEADER;
      scan_out.header.zero_run = '0;
      scan_out.header.width = (cov_width > max_nxt) ? cov_width : max_nxt;
      scan_out.header.value = '0;
      scan_out.header.element_count = covered_nxt;
      scan_out.header.end_of_block = 1'b1;
   end

   // block close drops trailing zeros and starts over
   always_comb begin
      position_in = position_ff;
      run_in = run_ff;
      max_in = max_ff;
      covered_in = covered_ff;
      if (fire) begin
         if (is_last) begin
            position_in = '0;
            run_in = '0;
            max_in = '0;
            covered_in = '0;
         end else begin
            position_in = position_ff + PosWidth'(1);
            run_in = run_nxt;
            max_in = max_nxt;
            covered_in = covered_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         run_ff <= '0;
         max_ff <= '0;
         covered_ff <= '0;
      end else begin
         position_ff <= position_in;
         run_ff <= run_in;
         max_ff <= max_in;
         covered_ff <= covered_in;
      end
   end

   `ZZRC_ASSERT_NEXT(a_close_clears, clock, reset, fire && is_last,
      position_ff == '0 && covered_ff == '0 && run_ff == '0, "block state not cleared on close")
   `ZZRC_ASSERT(a_cover_bound, clock, reset,
      covered_ff <= CountWidth'(position_ff), "covered count ahead of position")

endmodule

// ===== sv/zzrc_out_queue.sv =====
// small result queue taking up to two results per cycle
`include "assert_macros.svh"
module zzrc_out_queue import zzrc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push_en,
   input  scan_out_type scan_out,
   output logic room,
   output logic out_valid,
   input  logic out_ready,
   output rsp_type out_data
);

   rsp_type mem_ff [QueueDepth];
   logic [QueueIdxWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueueIdxWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;

   logic [1:0] n_push;
   logic pop;
   rsp_type slot0;

   always_comb begin
      n_push = push_en ? ({1'b0, scan_out.entry_valid} + {1'b0, scan_out.header_valid}) : 2'd0;
      slot0 = scan_out.entry_valid ? scan_out.entry : scan_out.header;
      out_valid = (count_ff != '0);
      out_data = mem_ff[rd_ptr_ff];
      pop = out_valid && out_ready;
      room = (count_ff <= QueueCntWidth'(QueueDepth - 2));
      wr_ptr_in = wr_ptr_ff + QueueIdxWidth'(n_push);
      rd_ptr_in = rd_ptr_ff + QueueIdxWidth'(pop);
      count_in = count_ff + QueueCntWidth'(n_push) - QueueCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ptr_ff] <= slot0;
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_ptr_ff + QueueIdxWidth'(1)] <= scan_out.header;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   `ZZRC_ASSERT(a_no_overflow, clock, reset,
      count_ff <= QueueCntWidth'(QueueDepth), "result queue over capacity")
   `ZZRC_ASSERT(a_push_room, clock, reset,
      !push_en || room, "results pushed without room")

endmodule

// ===== dv/zero_run_checker.sv =====
// checker for the zero run coder: predicts entries and block headers and compares results
module zero_run_checker import zzrc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic signed [CoeffWidth-1:0] req_coeff,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic rsp_kind,
   input  logic [RunWidth-1:0] rsp_zero_run,
   input  logic [WidthWidth-1:0] rsp_width,
   input  logic signed [CoeffWidth-1:0] rsp_value,
   input  logic [CountWidth-1:0] rsp_element_count,
   input  logic rsp_end_of_block,
   output int error_count,
   output int pending_results
);

   rsp_type expected_q[$];

   // predictor state for the block in progress
   logic [PosWidth-1:0] blk_pos;
   logic [RunWidth-1:0] zero_count;
   logic [WidthWidth-1:0] widest;
   logic [CountWidth-1:0] covered_len;

   function automatic int bit_len(input logic [CoeffWidth-1:0] v);
      int n;
      n = 0;
      while (v != 0) begin
         n++;
         v = v >> 1;
      end
      return n;
   endfunction

   task automatic predict_coeff(input logic signed [CoeffWidth-1:0] c);
      rsp_type r;
      logic [WidthWidth-1:0] w;
      logic [WidthWidth-1:0] cnt_w;
      if (c != 0) begin
         w = WidthWidth'(bit_len(c[CoeffWidth-1] ? ~c : c) + 1);
         r = '0;
         r.kind = KIND_ENTRY;
         r.zero_run = zero_count;
         r.width = w;
         r.value = c;
         expected_q = {expected_q, r};
         if (w > widest) widest = w;
         covered_len = covered_len + CountWidth'(zero_count) + 1'b1;
         zero_count = '0;
      end else begin
         zero_count = zero_count + 1'b1;
      end
      // any position at or past the last index closes the block
      if (int'(blk_pos) + 1 >= BlockLen) begin
         cnt_w = WidthWidth'(bit_len(CoeffWidth'(covered_len)));
         r = '0;
         r.kind = KIND_HEADER;
         r.width = (cnt_w > widest) ? cnt_w : widest;
         r.element_count = covered_len;
         r.end_of_block = 1'b1;
         expected_q = {expected_q, r};
         blk_pos = '0;
         zero_count = '0;
         widest = '0;
         covered_len = '0;
      end else begin
         blk_pos = blk_pos + 1'b1;
      end
   endtask

   task automatic check_field(input string name, input logic signed [31:0] exp_v,
                              input logic signed [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         expected_q.delete();
         blk_pos = '0;
         zero_count = '0;
         widest = '0;
         covered_len = '0;
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result item with no expectation waiting");
               error_count++;
            end else begin
               exp_r = expected_q.pop_front();
               check_field("kind", exp_r.kind, rsp_kind);
               check_field("zero_run", exp_r.zero_run, rsp_zero_run);
               check_field("width", exp_r.width, rsp_width);
               check_field("value", exp_r.value, rsp_value);
               check_field("element_count", exp_r.element_count, rsp_element_count);
               check_field("end_of_block", exp_r.end_of_block, rsp_end_of_block);
            end
         end
         if (req_valid && req_ready) predict_coeff(req_coeff);
      end
      pending_results = expected_q.size();
   end

endmodule

// ===== dv/tb.sv =====
// testbench top for the zero run coder: stimulus, backpressure and verdict
module tb import zzrc_pkg::*; ();

   logic clock;
   logic reset;
   int error_count;
   int pending_results;

   // idling controls, changed per block
   int gap_rate;
   int stall_rate;
   int stall_left;

   zzrc_req_if req_bus ();
   zzrc_rsp_if rsp_bus ();

   zigzag_zero_run_coder u_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   zero_run_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .req_coeff(req_bus.coeff),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .rsp_kind(rsp_bus.kind),
      .rsp_zero_run(rsp_bus.zero_run),
      .rsp_width(rsp_bus.width),
      .rsp_value(rsp_bus.value),
      .rsp_element_count(rsp_bus.element_count),
      .rsp_end_of_block(rsp_bus.end_of_block),
      .error_count(error_count),
      .pending_results(pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb NOT OK");
      $finish;
   end

   // result side: random stall bursts
   initial rsp_bus.ready = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_rate != 0 && $urandom_range(0, 7) < stall_rate) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_coeff(input logic signed [CoeffWidth-1:0] c);
      req_bus.valid <= 1'b1;
      req_bus.coeff <= c;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (gap_rate != 0 && $urandom_range(0, 7) < gap_rate) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // nonzero value of random signed width
   function automatic logic signed [CoeffWidth-1:0] random_nonzero();
      logic signed [CoeffWidth-1:0] r;
      r = CoeffWidth'($urandom);
      r = r >>> $urandom_range(0, CoeffWidth - 1);
      if (r == 0) r = 1;
      return r;
   endfunction

   task automatic send_random_block(input int style);
      logic signed [CoeffWidth-1:0] c;
      int stop_at;
      stop_at = $urandom_range(1, BlockLen);
      for (int i = 0; i < BlockLen; i++) begin
         c = '0;
         case (style)
            0: c = '0;
            1: if ($urandom_range(0, 7) == 0) c = random_nonzero();
            2: if ($urandom_range(0, 3) != 0) c = CoeffWidth'($urandom);
            3: begin
               if ($urandom_range(0, 5) == 0 || i == BlockLen - 1) c = random_nonzero();
            end
            default: begin
               // nonzeros early, then a trailing run of zeros
               if (i < stop_at && $urandom_range(0, 1) == 0) c = random_nonzero();
            end
         endcase
         send_coeff(c);
      end
   endtask

   initial begin
      logic signed [CoeffWidth-1:0] edge_vals[$];
      gap_rate = 0;
      stall_rate = 0;
      reset = 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.coeff <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes and small magnitudes, then trailing zeros
      edge_vals = '{16'sh7fff, -16'sh8000, 16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd2, -16'sd2,
                    16'sd0, 16'sh4000, -16'sh4001, 16'sd0, 16'sd0, 16'sd0, 16'sd255,
                    -16'sd256, 16'sd127, -16'sd128, 16'sh5555, -16'sh5556};
      for (int i = 0; i < BlockLen; i++) begin
         send_coeff(i < edge_vals.size() ? edge_vals[i] : 16'sd0);
      end
      // all-zero block
      send_random_block(0);
      // longest run, last coefficient nonzero: the count width dominates
      for (int i = 0; i < BlockLen; i++) send_coeff(i == BlockLen - 1 ? 16'sd1 : 16'sd0);

      for (int b = 0; b < 14; b++) begin
         if (b < 12) begin
            gap_rate = $urandom_range(0, 3);
            stall_rate = $urandom_range(0, 4);
         end else begin
            gap_rate = 0;
            stall_rate = 0;
         end
         send_random_block(b == 0 ? 2 : $urandom_range(0, 4));
      end
      req_bus.valid <= 1'b0;

      // let the checker see the last accepted item before polling its backlog
      do @(negedge clock); while (pending_results != 0);
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_results == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
